// ----- hdl/xstar_pkg.sv -----
// ============================================================================
// xstar_pkg: shared types, constants and functions
// Item kind codes, generator constants, the steps and the full form of the
// 64-bit integer hash used by the seed path, and the generator's xor-shifts.
// ============================================================================
package xstar_pkg;

  typedef logic [63:0] word_t;
  typedef logic [1:0]  kind_t;
  typedef logic [2:0]  mix_idx_t;

  localparam kind_t KIND_DRAW   = 2'd0;
  localparam kind_t KIND_RESEED = 2'd1;
  localparam kind_t KIND_LOAD   = 2'd2;

  localparam word_t MULT_STAR    = 64'h2545F4914F6CDD1D;
  localparam word_t DEFAULT_SEED = 64'h0139408DCBBF7A44;

  // Steps of the integer hash, one applied per cycle by the hash unit.
  localparam mix_idx_t MIX_NOT_ADD21 = 3'd0;
  localparam mix_idx_t MIX_XOR24     = 3'd1;
  localparam mix_idx_t MIX_MUL265    = 3'd2;
  localparam mix_idx_t MIX_XOR14     = 3'd3;
  localparam mix_idx_t MIX_MUL21     = 3'd4;
  localparam mix_idx_t MIX_XOR28     = 3'd5;
  localparam mix_idx_t MIX_ADD31     = 3'd6;
  localparam mix_idx_t MIX_LAST      = MIX_ADD31;

  // One hash step. The small multiplications are written as shift-adds.
  function automatic word_t mix_step(input word_t k, input mix_idx_t idx);
    word_t r;
    unique case (idx)
      MIX_NOT_ADD21: r = (~k) + (k << 21);
      MIX_XOR24:     r = k ^ (k >> 24);
      MIX_MUL265:    r = k + (k << 3) + (k << 8);
      MIX_XOR14:     r = k ^ (k >> 14);
      MIX_MUL21:     r = k + (k << 2) + (k << 4);
      MIX_XOR28:     r = k ^ (k >> 28);
      MIX_ADD31:     r = k + (k << 31);
      default:       r = k;
    endcase
    return r;
  endfunction

  // Full hash, evaluated only at elaboration for the reset state.
  function automatic word_t mix_full(input word_t k);
    word_t r;
    r = k;
    for (int i = 0; i <= int'(MIX_LAST); i++) begin
      r = mix_step(r, mix_idx_t'(i));
    end
    return r;
  endfunction

  function automatic word_t hashed_state(input word_t s);
    word_t h;
    h = mix_full(s);
    if (h == '0) begin
      h = mix_full(h);
    end
    return h;
  endfunction

  localparam word_t RESET_STATE = hashed_state(DEFAULT_SEED);

  // Three xor-shifts of the generator; cheap enough to evaluate combinationally.
  function automatic word_t xorshift_next(input word_t s);
    word_t r;
    r = s ^ (s >> 12);
    r = r ^ (r << 25);
    r = r ^ (r >> 27);
    return r;
  endfunction

endpackage

// ----- hdl/xstar_in_if.sv -----
// ============================================================================
// xstar_in_if: input item channel
// Valid/ready channel carrying the item kind and its 64-bit value.
// ============================================================================
interface xstar_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// ----- hdl/xstar_out_if.sv -----
// ============================================================================
// xstar_out_if: result item channel
// Valid/ready channel carrying the number, the state and the stored seed.
// ============================================================================
interface xstar_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] number;
  logic [63:0] current_state;
  logic [63:0] current_seed;

  modport source (output valid, output number, output current_state,
                  output current_seed, input ready);
  modport sink   (input valid, input number, input current_state,
                  input current_seed, output ready);
endinterface

// ----- hdl/xstar_mul.sv -----
// ============================================================================
// xstar_mul: iterative truncated multiplier
// Forms the low 64 bits of a times the output constant with one shared
// 32x32 multiplier over three partial products.
// ============================================================================
module xstar_mul
  import xstar_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t a,
  output logic  done,
  output word_t prod
);

  localparam logic [1:0] PH_LL  = 2'd0;
  localparam logic [1:0] PH_HL  = 2'd1;
  localparam logic [1:0] PH_LH  = 2'd2;
  localparam logic [1:0] PH_END = 2'd3;

  logic        busy_r;
  logic        done_r;
  logic [1:0]  cnt_r;
  word_t       a_r;
  word_t       p_r;
  word_t       acc_r;
  logic [31:0] op_x;
  logic [31:0] op_y;
  word_t       p_nxt;

  always_comb begin
    unique case (cnt_r)
      PH_LL: begin
        op_x = a_r[31:0];
        op_y = MULT_STAR[31:0];
      end
      PH_HL: begin
        op_x = a_r[63:32];
        op_y = MULT_STAR[31:0];
      end
      PH_LH: begin
        op_x = a_r[31:0];
        op_y = MULT_STAR[63:32];
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
    p_nxt = {32'd0, op_x} * {32'd0, op_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= PH_LL;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= PH_LL;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == PH_END) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The product of one phase is accumulated in the next one.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
    end
    if (busy_r) begin
      p_r <= p_nxt;
      if (cnt_r == PH_HL) begin
        acc_r <= p_r;
      end else if (cnt_r != PH_LL) begin
        acc_r[63:32] <= acc_r[63:32] + p_r[31:0];
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ----- hdl/xstar_hash.sv -----
// ============================================================================
// xstar_hash: iterative seed hash
// Applies one step of the 64-bit integer hash per cycle and repeats the
// whole hash once more when the first pass yields zero.
// ============================================================================
module xstar_hash
  import xstar_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t seed,
  output logic  done,
  output word_t hash
);

  logic     busy_r;
  logic     done_r;
  logic     round2_r;
  mix_idx_t step_r;
  word_t    k_r;
  word_t    k_nxt;

  assign k_nxt = mix_step(k_r, step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      round2_r <= 1'b0;
      step_r   <= MIX_NOT_ADD21;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        round2_r <= 1'b0;
        step_r   <= MIX_NOT_ADD21;
      end else if (busy_r) begin
        if (step_r == MIX_LAST) begin
          step_r <= MIX_NOT_ADD21;
          // A zero hash is hashed again; the hash of zero is never zero.
          if (k_nxt == '0 && !round2_r) begin
            round2_r <= 1'b1;
          end else begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r <= seed;
    end else if (busy_r) begin
      k_r <= k_nxt;
    end
  end

  assign done = done_r;
  assign hash = k_r;

endmodule

// ----- hdl/xorshift64star_rng_hashed_seed.sv -----
// ============================================================================
// xorshift64star_rng_hashed_seed: 64-bit xorshift* generator
// Draws, reseeds through a 64-bit integer hash, and raw state loads, with one
// result item for every input item.
// ============================================================================
//
//   Channel  Direction  Handshake           Payload
//   in_if    sink       valid / ready       kind[1:0], value[63:0]
//   out_if   source     valid / ready       number, current_state, current_seed
//
// A draw applies the three xor-shifts at acceptance; then the shared 32x32
// multiplier forms three partial products of the new state and the output
// constant in its phases LL, HL and LH, and sums them by its END phase.
// A reseed runs the hash unit, which applies one of its seven steps per
// cycle and makes a second pass when the first pass gives zero. A load or an
// unused kind goes straight to the done state. The result waits in the done
// state until the output register is free; the block takes a new item as
// soon as the result enters the output register. One result may wait on
// out_if while the next item is already at work; the block stalls only if a
// second result is ready before the first is taken.
// Reset is synchronous and active low; it restores the default seed and its
// hash as the state.
//
module xorshift64star_rng_hashed_seed
  import xstar_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  xstar_in_if.sink    in_if,
  xstar_out_if.source out_if
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_HASH = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       is_draw_r;
  word_t      gen_state_r;
  word_t      seed_r;

  logic       out_valid_r;
  word_t      out_number_r;
  word_t      out_state_r;
  word_t      out_seed_r;

  logic       in_acc;
  logic       out_free;
  word_t      drawn;

  logic       mul_start;
  logic       mul_done;
  word_t      mul_prod;
  logic       hash_start;
  logic       hash_done;
  word_t      hash_val;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  // The output register can take a new result when it is empty or being read.
  assign out_free    = !out_valid_r || out_if.ready;
  assign drawn       = xorshift_next(gen_state_r);

  assign mul_start  = in_acc && (in_if.kind == KIND_DRAW);
  assign hash_start = in_acc && (in_if.kind == KIND_RESEED);

  xstar_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (drawn),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  xstar_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .seed  (in_if.value),
    .done  (hash_done),
    .hash  (hash_val)
  );

  // The sequencer waits on whichever unit the item started, if there is one,
  // then holds in the done state until the output register is free.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_if.kind)
            KIND_DRAW:   state_nxt = ST_MUL;
            KIND_RESEED: state_nxt = ST_HASH;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      is_draw_r   <= 1'b0;
      gen_state_r <= RESET_STATE;
      seed_r      <= DEFAULT_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        is_draw_r <= (in_if.kind == KIND_DRAW);
        unique case (in_if.kind)
          KIND_DRAW:   gen_state_r <= drawn;
          KIND_RESEED: seed_r      <= in_if.value;
          KIND_LOAD:   gen_state_r <= in_if.value;
          default:     ;
        endcase
      end
      if (state_r == ST_HASH && hash_done) begin
        gen_state_r <= hash_val;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; the multiplier holds its product until its next start.
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_number_r <= is_draw_r ? mul_prod : '0;
      out_state_r  <= gen_state_r;
      out_seed_r   <= seed_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.number        = out_number_r;
  assign out_if.current_state = out_state_r;
  assign out_if.current_seed  = out_seed_r;

endmodule

// ----- hdl/xstar_chk.sv -----
// ============================================================================
// xstar_chk: port-level checker
// Watches the channels of the generator and is bound to its top level.
// ============================================================================
module xstar_chk
  import xstar_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input word_t out_number,
  input word_t out_current_state,
  input word_t out_current_seed
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item present right after reset");

  // Every accepted item moves the sequencer out of idle, so the input closes after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready the cycle after an item was taken");

  // A result that waits keeps its values until it is taken.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_number)
      && $stable(out_current_state) && $stable(out_current_seed))
    else $error("waiting result item changed or vanished");

  // A new result can only appear while the input side is closed or just
  // reopening, never in the middle of an accepted item's first cycle.
  a_no_result_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result item appeared one cycle after an item was taken");

endmodule

bind xorshift64star_rng_hashed_seed xstar_chk u_xstar_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_number        (out_if.number),
  .out_current_state (out_if.current_state),
  .out_current_seed  (out_if.current_seed)
);
